### rtl/core/rmq_pkg.sv
// Shared constants, payload types and branch codes for the rotation matrix
// to quaternion pipeline. No dependencies.
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int FIELD_W   = 16;
  // A sum or difference of two entries.
  localparam int NUM_W     = FIELD_W + 1;
  // Unsigned root argument after clamping.
  localparam int ARG_W     = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
  // Radicand is the argument scaled by one, rounded up to an even width.
  localparam int RAD_W     = ((ARG_W + FRAC_BITS + 1) / 2) * 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int S_W       = ROOT_W + 1;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DVD_W     = NUM_W + FRAC_BITS;
  localparam int MAX_POS   = 2 ** (FIELD_W - 1) - 1;
  localparam int MAX_NEG   = 2 ** (FIELD_W - 1);

  // Branch codes: which quaternion part is built from the root.
  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  // Beat payload leaving the front stage: branch and three numerators,
  // ordered by ascending output position with the branch's part skipped.
  typedef struct packed {
    logic [1:0]  sel;
    num_t [2:0]  num;
  } front_t;

  // Beat payload riding along the divider lanes.
  typedef struct packed {
    logic [1:0]     sel;
    field_t         big;
    logic [S_W-1:0] s;
    logic [2:0]     neg;
  } div_pay_t;

endpackage

### rtl/core/rmq_front.sv
// Front stage: trace, branch choice, clamped root argument and numerators.
// Depends on rmq_pkg.
module rmq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rmq_pkg::field_t [8:0]        in_m,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rmq_pkg::RAD_W-1:0]    out_rad,
  output rmq_pkg::front_t              out_pay
);
  import rmq_pkg::*;

  localparam logic signed [ARG_W:0] ONE = (ARG_W + 1)'(2 ** FRAC_BITS);

  logic                    v_r;
  logic [RAD_W-1:0]        rad_r, rad_nxt;
  front_t                  pay_r, pay_nxt;
  logic signed [NUM_W:0]   trace;
  logic signed [ARG_W:0]   e00, e11, e22, arg_s;
  logic [ARG_W-1:0]        arg_u;
  num_t                    d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

  // Branch selection, root argument and numerators.
  always_comb begin
    trace = (NUM_W + 1)'(in_m[0]) + (NUM_W + 1)'(in_m[4]) + (NUM_W + 1)'(in_m[8]);
    e00 = (ARG_W + 1)'(in_m[0]);
    e11 = (ARG_W + 1)'(in_m[4]);
    e22 = (ARG_W + 1)'(in_m[8]);
    d21_12 = NUM_W'(in_m[7]) - NUM_W'(in_m[5]);
    d02_20 = NUM_W'(in_m[2]) - NUM_W'(in_m[6]);
    d10_01 = NUM_W'(in_m[3]) - NUM_W'(in_m[1]);
    s01_10 = NUM_W'(in_m[1]) + NUM_W'(in_m[3]);
    s02_20 = NUM_W'(in_m[2]) + NUM_W'(in_m[6]);
    s12_21 = NUM_W'(in_m[5]) + NUM_W'(in_m[7]);
    if (trace > 0) begin
      pay_nxt.sel = SEL_W;
      arg_s = ONE + e00 + e11 + e22;
      pay_nxt.num = {d10_01, d02_20, d21_12};
    end else if (in_m[0] > in_m[4] && in_m[0] > in_m[8]) begin
      pay_nxt.sel = SEL_X;
      arg_s = ONE + e00 - e11 - e22;
      pay_nxt.num = {s02_20, s01_10, d21_12};
    end else if (in_m[4] > in_m[8]) begin
      pay_nxt.sel = SEL_Y;
      arg_s = ONE + e11 - e00 - e22;
      pay_nxt.num = {s12_21, s01_10, d02_20};
    end else begin
      pay_nxt.sel = SEL_Z;
      arg_s = ONE + e22 - e00 - e11;
      pay_nxt.num = {s12_21, s02_20, d10_01};
    end
    // A negative argument is clamped to zero.
    arg_u   = arg_s[ARG_W] ? '0 : arg_s[ARG_W-1:0];
    rad_nxt = RAD_W'(arg_u) << FRAC_BITS;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rad_r <= rad_nxt;
      pay_r <= pay_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_rad   = rad_r;
  assign out_pay   = pay_r;

endmodule

### rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage, carrying the
// front payload alongside. Depends on rmq_pkg.
module rmq_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rmq_pkg::RAD_W-1:0]    in_rad,
  input  rmq_pkg::front_t              in_pay,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rmq_pkg::ROOT_W-1:0]   out_root,
  output rmq_pkg::front_t              out_pay
);
  import rmq_pkg::*;

  localparam int N = ROOT_W;

  logic [N-1:0]        v_r;
  logic [N:0]          rdy;
  logic [RAD_W-1:0]    rad_r  [N];
  logic [REM_W-1:0]    rem_r  [N];
  logic [ROOT_W-1:0]   root_r [N];
  front_t              pay_r  [N];
  logic [RAD_W-1:0]    rad_nxt  [N];
  logic [REM_W-1:0]    rem_nxt  [N];
  logic [ROOT_W-1:0]   root_nxt [N];
  front_t              pay_nxt  [N];

  // Stall chain: a stage loads when it is empty or its successor loads.
  always_comb begin
    rdy[N] = out_ready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // One digit step per stage.
  always_comb begin
    logic [RAD_W-1:0]  rad_s;
    logic [REM_W-1:0]  rem_s, rem_t, trial;
    logic [ROOT_W-1:0] root_s;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rad_s      = in_rad;
        rem_s      = '0;
        root_s     = '0;
        pay_nxt[k] = in_pay;
      end else begin
        rad_s      = rad_r[k-1];
        rem_s      = rem_r[k-1];
        root_s     = root_r[k-1];
        pay_nxt[k] = pay_r[k-1];
      end
      rem_t = {rem_s[REM_W-3:0], rad_s[RAD_W-1:RAD_W-2]};
      trial = {root_s, 2'b01};
      if (rem_t >= trial) begin
        rem_nxt[k]  = rem_t - trial;
        root_nxt[k] = {root_s[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_t;
        root_nxt[k] = {root_s[ROOT_W-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_s[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (rdy[k]) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        pay_r[k]  <= pay_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_pay   = pay_r[N-1];

  // The partial remainder never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N-1] |-> (rem_r[N-1] <= REM_W'({root_r[N-1], 1'b0})))
    else $error("sqrt remainder out of bound");

endmodule

### rtl/core/rmq_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage, that
// divides the scaled numerator magnitudes by S. Depends on rmq_pkg.
module rmq_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rmq_pkg::ROOT_W-1:0]   in_root,
  input  rmq_pkg::front_t              in_pay,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rmq_pkg::DVD_W-1:0]    out_quot [3],
  output rmq_pkg::div_pay_t            out_pay
);
  import rmq_pkg::*;

  localparam int N = DVD_W;

  logic [N-1:0]        v_r;
  logic [N:0]          rdy;
  logic [DVD_W-1:0]    dvd_r [N][3];
  logic [REM_W-1:0]    rem_r [N][3];
  div_pay_t            pay_r [N];
  logic [DVD_W-1:0]    dvd_nxt [N][3];
  logic [REM_W-1:0]    rem_nxt [N][3];
  div_pay_t            pay_nxt [N];
  div_pay_t            pay_in;
  logic [DVD_W-1:0]    dvd_in [3];
  logic [ROOT_W-1:0]   root_half;

  // Entry: divisor, branch part, signs and scaled magnitudes.
  always_comb begin
    logic [NUM_W-1:0] mag;
    root_half  = in_root >> 1;
    pay_in.sel = in_pay.sel;
    pay_in.s   = {in_root, 1'b0};
    pay_in.big = (root_half > ROOT_W'(MAX_POS)) ? field_t'(MAX_POS) : FIELD_W'(root_half);
    for (int l = 0; l < 3; l++) begin
      pay_in.neg[l] = in_pay.num[l][NUM_W-1];
      mag = in_pay.num[l][NUM_W-1] ? NUM_W'(-in_pay.num[l]) : NUM_W'(in_pay.num[l]);
      dvd_in[l] = DVD_W'(mag) << FRAC_BITS;
    end
  end

  // Stall chain.
  always_comb begin
    rdy[N] = out_ready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // One quotient bit per stage and lane.
  always_comb begin
    logic [DVD_W-1:0] dvd_s;
    logic [REM_W-1:0] rem_s, rem_t, div_s;
    for (int k = 0; k < N; k++) begin
      pay_nxt[k] = (k == 0) ? pay_in : pay_r[k-1];
      div_s = REM_W'(pay_nxt[k].s);
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          dvd_s = dvd_in[l];
          rem_s = '0;
        end else begin
          dvd_s = dvd_r[k-1][l];
          rem_s = rem_r[k-1][l];
        end
        rem_t = {rem_s[REM_W-2:0], dvd_s[DVD_W-1]};
        if (rem_t >= div_s) begin
          rem_nxt[k][l] = rem_t - div_s;
          dvd_nxt[k][l] = {dvd_s[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][l] = rem_t;
          dvd_nxt[k][l] = {dvd_s[DVD_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (rdy[k]) begin
        pay_r[k] <= pay_nxt[k];
        for (int l = 0; l < 3; l++) begin
          dvd_r[k][l] <= dvd_nxt[k][l];
          rem_r[k][l] <= rem_nxt[k][l];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_pay   = pay_r[N-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_quot[l] = dvd_r[N-1][l];
    end
  end

  // With a nonzero divisor the final remainder of lanes 0 and 2 lies below it.
  a_rem_lt_s: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N-1] && (pay_r[N-1].s != '0) |->
      (rem_r[N-1][0] < REM_W'(pay_r[N-1].s)) && (rem_r[N-1][2] < REM_W'(pay_r[N-1].s)))
    else $error("divider remainder not below divisor");

  // A zero divisor only comes from a zero root, so the branch part is zero.
  a_zero_big: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N-1] && (pay_r[N-1].s == '0) |-> (pay_r[N-1].big == '0))
    else $error("zero divisor with nonzero branch part");

endmodule

### rtl/core/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion top level: front stage, square root, divider
// and the saturating output register. Depends on rmq_pkg and the rmq_ modules.
//
// Takes one 3x3 matrix beat per cycle unless stalled and returns one quaternion
// beat per matrix, in order, through one front stage, one square root stage per
// root bit and one divider stage per quotient bit of the scaled numerator, then
// the output register. Every stage holds its own valid bit, so a stalled output
// only stops the beats behind it, and empty stages keep filling.
module rotation_matrix_to_quaternion_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rmq_pkg::field_t in_m00,
  input  rmq_pkg::field_t in_m01,
  input  rmq_pkg::field_t in_m02,
  input  rmq_pkg::field_t in_m10,
  input  rmq_pkg::field_t in_m11,
  input  rmq_pkg::field_t in_m12,
  input  rmq_pkg::field_t in_m20,
  input  rmq_pkg::field_t in_m21,
  input  rmq_pkg::field_t in_m22,
  output logic            out_valid,
  input  logic            out_ready,
  output rmq_pkg::field_t out_quat_w,
  output rmq_pkg::field_t out_quat_x,
  output rmq_pkg::field_t out_quat_y,
  output rmq_pkg::field_t out_quat_z
);
  import rmq_pkg::*;

  field_t [8:0]       m;
  logic               f_valid, f_ready, q_valid, q_ready, d_valid, d_ready;
  logic [RAD_W-1:0]   f_rad;
  front_t             f_pay, q_pay;
  logic [ROOT_W-1:0]  q_root;
  logic [DVD_W-1:0]   d_quot [3];
  div_pay_t           d_pay;
  logic               out_valid_r;
  field_t [3:0]       quat_r, quat_nxt;
  field_t [2:0]       lane_val;

  assign m = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  rmq_front u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_m(m),
    .out_valid(f_valid), .out_ready(f_ready), .out_rad(f_rad), .out_pay(f_pay)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst_n,
    .in_valid(f_valid), .in_ready(f_ready), .in_rad(f_rad), .in_pay(f_pay),
    .out_valid(q_valid), .out_ready(q_ready), .out_root(q_root), .out_pay(q_pay)
  );

  rmq_div u_div (
    .clk, .rst_n,
    .in_valid(q_valid), .in_ready(q_ready), .in_root(q_root), .in_pay(q_pay),
    .out_valid(d_valid), .out_ready(d_ready), .out_quot(d_quot), .out_pay(d_pay)
  );

  // Sign, zero-divisor masking and saturation of each divided lane.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (d_pay.s == '0) begin
        lane_val[l] = '0;
      end else if (d_pay.neg[l]) begin
        lane_val[l] = (d_quot[l] > DVD_W'(MAX_NEG)) ? field_t'(-MAX_NEG)
                                                    : FIELD_W'(-d_quot[l]);
      end else begin
        lane_val[l] = (d_quot[l] > DVD_W'(MAX_POS)) ? field_t'(MAX_POS)
                                                    : FIELD_W'(d_quot[l]);
      end
    end
  end

  // Place the branch part and the three lanes at their output positions.
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (2'(p) == d_pay.sel) begin
        quat_nxt[p] = d_pay.big;
      end else if (2'(p) < d_pay.sel) begin
        quat_nxt[p] = lane_val[p];
      end else begin
        quat_nxt[p] = lane_val[p-1];
      end
    end
  end

  // Output register.
  assign d_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      quat_r <= quat_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = quat_r[0];
  assign out_quat_x = quat_r[1];
  assign out_quat_y = quat_r[2];
  assign out_quat_z = quat_r[3];

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  // A zero divisor yields an all-zero quaternion.
  a_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid && d_ready && (d_pay.s == '0) |=> (quat_r == '0))
    else $error("zero divisor gave nonzero quaternion");

endmodule

### tb/rotation_matrix_to_quaternion_unit_checker.sv
// Checker for the rotation matrix to quaternion unit: watches both channels,
// predicts each quaternion from the accepted matrix and compares. Uses rmq_pkg.
module rotation_matrix_to_quaternion_unit_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  rmq_pkg::field_t in_m00, in_m01, in_m02,
  input  rmq_pkg::field_t in_m10, in_m11, in_m12,
  input  rmq_pkg::field_t in_m20, in_m21, in_m22,
  input  logic            out_valid,
  input  logic            out_ready,
  input  rmq_pkg::field_t out_quat_w, out_quat_x, out_quat_y, out_quat_z,
  output int              fail_count,
  output int              pending_quats
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  typedef struct packed {
    field_t w, x, y, z;
  } quat_t;

  quat_t quat_fifo[$];

  // Integer square root by bit pairs.
  function automatic longint isqrt(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 60;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic field_t scaled_ratio(longint n, longint s);
    if (s <= 0) return '0;
    return field_t'(clip16((n * (longint'(1) << FRAC_BITS)) / s));
  endfunction

  // Four-branch method: pick the branch, take the root, divide the rest.
  function automatic quat_t matrix_to_quat(longint a00, a01, a02, a10, a11, a12,
                                           a20, a21, a22);
    longint one, tr, arg, r, s;
    logic [1:0] br;
    field_t big;
    quat_t q;
    one = longint'(1) << FRAC_BITS;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      br = SEL_W; arg = tr + one;
    end else if (a00 > a11 && a00 > a22) begin
      br = SEL_X; arg = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      br = SEL_Y; arg = one + a11 - a00 - a22;
    end else begin
      br = SEL_Z; arg = one + a22 - a00 - a11;
    end
    if (arg < 0) arg = 0;
    r = isqrt(arg << FRAC_BITS);
    s = 2 * r;
    big = field_t'(clip16(r >>> 1));
    case (br)
      SEL_W: begin
        q.w = big;
        q.x = scaled_ratio(a21 - a12, s);
        q.y = scaled_ratio(a02 - a20, s);
        q.z = scaled_ratio(a10 - a01, s);
      end
      SEL_X: begin
        q.w = scaled_ratio(a21 - a12, s);
        q.x = big;
        q.y = scaled_ratio(a01 + a10, s);
        q.z = scaled_ratio(a02 + a20, s);
      end
      SEL_Y: begin
        q.w = scaled_ratio(a02 - a20, s);
        q.x = scaled_ratio(a01 + a10, s);
        q.y = big;
        q.z = scaled_ratio(a12 + a21, s);
      end
      default: begin
        q.w = scaled_ratio(a10 - a01, s);
        q.x = scaled_ratio(a02 + a20, s);
        q.y = scaled_ratio(a12 + a21, s);
        q.z = big;
      end
    endcase
    return q;
  endfunction

  assign pending_quats = quat_fifo.size();

  // Sample both channels at the edge; inputs settle away from it.
  always @(posedge clk) begin
    quat_t exp_q, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        quat_fifo.push_back(matrix_to_quat(in_m00, in_m01, in_m02, in_m10, in_m11,
                                           in_m12, in_m20, in_m21, in_m22));
      if (out_valid && out_ready) begin
        got = '{out_quat_w, out_quat_x, out_quat_y, out_quat_z};
        if (quat_fifo.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("Unexpected quaternion beat w=%0d x=%0d y=%0d z=%0d",
                     got.w, got.x, got.y, got.z);
        end else begin
          exp_q = quat_fifo.pop_front();
          if (got !== exp_q) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Mismatch: expected w=%0d x=%0d y=%0d z=%0d, got %0d %0d %0d %0d",
                       exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                       got.w, got.x, got.y, got.z);
          end
        end
      end
    end
  end
endmodule

### tb/rotation_matrix_to_quaternion_unit_test.sv
// Top of the rotation matrix to quaternion testbench: clock, reset, matrix
// stimulus and verdict. Depends on rmq_pkg, the unit and its checker.
module rotation_matrix_to_quaternion_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 200;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  field_t m[9];
  logic   out_valid;
  logic   out_ready = 1'b0;
  field_t q_w, q_x, q_y, q_z;
  int     fail_count, pending_quats;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;

  initial foreach (m[i]) m[i] = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rotation_matrix_to_quaternion_unit dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_m00(m[0]), .in_m01(m[1]), .in_m02(m[2]),
    .in_m10(m[3]), .in_m11(m[4]), .in_m12(m[5]),
    .in_m20(m[6]), .in_m21(m[7]), .in_m22(m[8]),
    .out_valid, .out_ready,
    .out_quat_w(q_w), .out_quat_x(q_x), .out_quat_y(q_y), .out_quat_z(q_z)
  );

  rotation_matrix_to_quaternion_unit_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_m00(m[0]), .in_m01(m[1]), .in_m02(m[2]),
    .in_m10(m[3]), .in_m11(m[4]), .in_m12(m[5]),
    .in_m20(m[6]), .in_m21(m[7]), .in_m22(m[8]),
    .out_valid, .out_ready,
    .out_quat_w(q_w), .out_quat_x(q_x), .out_quat_y(q_y), .out_quat_z(q_z),
    .fail_count, .pending_quats
  );

  // Result side stalls at random except during the calm stretch.
  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 37);

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL rotation_matrix_to_quaternion_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one matrix beat and hold it until accepted; valid drops only
  // while idling between beats.
  task automatic send_matrix(input field_t e[9]);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    foreach (e[i]) m[i] <= e[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic field_t any_entry();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return field_t'($urandom_range(32767));
      default: return field_t'($urandom);
    endcase
  endfunction

  // A near rotation: unit-ish diagonal with small mixed terms.
  function automatic field_t near_entry(bit diag);
    int v;
    v = diag ? $urandom_range(16384) - ($urandom_range(1) ? 0 : 16384)
             : int'($urandom_range(16000)) - 8000;
    return field_t'(v);
  endfunction

  initial begin
    field_t e[9];
    field_t dir[14][9];
    // Directed matrices: identity, each branch, ties, zero trace, extremes.
    dir = '{
      '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
      '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
      '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384},
      '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{100, 5, -7, 9, 100, 3, 2, -4, -200},
      '{-100, 1, 2, 3, -100, 4, 5, 6, -100},
      '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
      '{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768},
      '{-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, -32768},
      '{0, -1, 0, 1, 0, -1, 0, 1, 0},
      '{-1, 0, 0, 0, -1, 0, 0, 0, -32768}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[k]) send_matrix(dir[k]);

    for (int n = 0; n < 600; n++) begin
      calm = (n >= 250 && n < 330);
      if ($urandom_range(3) == 0) begin
        foreach (e[i]) e[i] = any_entry();
      end else begin
        foreach (e[i]) e[i] = near_entry(i % 4 == 0);
      end
      send_matrix(e);
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle.
    while (pending_quats != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("PASS rotation_matrix_to_quaternion_unit");
    else
      $display("FAIL rotation_matrix_to_quaternion_unit");
    $finish;
  end
endmodule
